// ----- sv/cstrip_pkg.sv -----
// cstrip_pkg: shared types and constants of the comment stripper
// holds the beat payload structs, the text state and character codes
// no dependencies
`default_nettype none

package cstrip_pkg;

  // character codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // configuration register map
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 32;
  localparam int unsigned MODES_W     = 3;
  localparam logic [MODES_W-1:0] MODES_RESET = 3'd1;
  localparam logic [CFG_AW-3:0]  REG_MODES   = 1'b0;

  // mode bits
  localparam int unsigned MODE_SLASH = 0;
  localparam int unsigned MODE_HASH  = 1;
  localparam int unsigned MODE_BLOCK = 2;

  // result queue sizing
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;
  } out_beat_t;

  // per-text scanner state
  typedef struct packed {
    logic [7:0] held_char;
    logic       held_valid;
    logic [7:0] prev_raw;
    logic       in_line_comment;
    logic       in_block_comment;
    logic       star_pending;
  } text_state_t;

  // results of one input beat, zero to two of them
  typedef struct packed {
    logic [1:0] n;
    out_beat_t  r0;
    out_beat_t  r1;
  } push_t;

endpackage

`default_nettype wire

// ----- sv/cstrip_if.sv -----
// cstrip_in_if / cstrip_out_if: valid-ready channels of the comment stripper
// input channel carries raw bytes, output channel carries kept bytes
// no dependencies
`default_nettype none

interface cstrip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface cstrip_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, output out_byte, output has_byte, output end_of_text,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input end_of_text,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/cstrip_core.sv -----
// cstrip_core: per-byte comment scanner, pure combinational step
// takes the text state and one raw byte, gives the next state and 0..2 results
// depends on cstrip_pkg
`default_nettype none

module cstrip_core (
  input  wire cstrip_pkg::text_state_t     st,
  input  wire [cstrip_pkg::MODES_W-1:0]    modes,
  input  wire [7:0]                        c,
  input  wire                              last,
  output cstrip_pkg::text_state_t          st_nxt,
  output cstrip_pkg::push_t                push
);

  logic       blk;
  logic       slash;
  logic       hash;
  logic       unesc;
  logic       take;
  logic       emit_held;
  logic       emit_cur;
  logic       emit_flush;
  logic [7:0] flush_char;
  logic [1:0] cnt;
  cstrip_pkg::text_state_t s;
  cstrip_pkg::out_beat_t   b_held;
  cstrip_pkg::out_beat_t   b_cur;
  cstrip_pkg::out_beat_t   b_flush;

  // mode decode, block mode overrides line modes
  assign blk   = modes[cstrip_pkg::MODE_BLOCK];
  assign slash = !blk && modes[cstrip_pkg::MODE_SLASH];
  assign hash  = !blk && modes[cstrip_pkg::MODE_HASH];
  assign unesc = (st.prev_raw != cstrip_pkg::CH_BSLASH);

  // scanner state update
  always_comb begin
    s          = st;
    take       = 1'b1;
    emit_held  = 1'b0;
    emit_cur   = 1'b0;
    if (st.in_line_comment) begin
      if (c == cstrip_pkg::CH_NL) s.in_line_comment = 1'b0;
    end else if (st.in_block_comment) begin
      if (st.star_pending && c == cstrip_pkg::CH_SLASH) begin
        s.in_block_comment = 1'b0;
        s.star_pending     = 1'b0;
      end else begin
        s.star_pending = (c == cstrip_pkg::CH_STAR) && unesc;
      end
    end else begin
      if (st.held_valid) begin
        s.held_valid = 1'b0;
        if (blk && c == cstrip_pkg::CH_STAR) begin
          s.in_block_comment = 1'b1;
          s.star_pending     = 1'b0;
          take               = 1'b0;
        end else if (slash && c == cstrip_pkg::CH_SLASH) begin
          s.in_line_comment = 1'b1;
          take              = 1'b0;
        end else begin
          emit_held = 1'b1;
        end
      end
      if (take) begin
        if (hash && c == cstrip_pkg::CH_HASH && unesc) begin
          s.in_line_comment = 1'b1;
        end else if ((blk || slash) && c == cstrip_pkg::CH_SLASH && unesc) begin
          s.held_char  = c;
          s.held_valid = 1'b1;
        end else begin
          emit_cur = 1'b1;
        end
      end
    end
    s.prev_raw = c;
  end

  // end of text flushes the held slash and clears the text state
  assign emit_flush = last && s.held_valid;
  assign flush_char = s.held_char;
  assign st_nxt     = last ? '0 : s;

  assign cnt = {1'b0, emit_held} + {1'b0, emit_cur} + {1'b0, emit_flush};

  assign b_held  = '{out_byte: st.held_char, has_byte: 1'b1, end_of_text: 1'b0};
  assign b_cur   = '{out_byte: c,            has_byte: 1'b1, end_of_text: 1'b0};
  assign b_flush = '{out_byte: flush_char,   has_byte: 1'b1, end_of_text: 1'b0};

  // pack results in order, add the empty end marker when nothing came out
  always_comb begin
    push.r0 = emit_held ? b_held : (emit_cur ? b_cur : b_flush);
    push.r1 = (emit_held && emit_cur) ? b_cur : b_flush;
    push.n  = cnt;
    if (last) begin
      if (cnt == 2'd0) begin
        push.n  = 2'd1;
        push.r0 = '{out_byte: 8'h00, has_byte: 1'b0, end_of_text: 1'b1};
      end else if (cnt == 2'd1) begin
        push.r0.end_of_text = 1'b1;
      end else begin
        push.r1.end_of_text = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/cstrip_outq.sv -----
// cstrip_outq: small result queue, takes up to two beats a cycle, gives one
// decouples the scanner from a stalling receiver
// depends on cstrip_pkg
`default_nettype none

module cstrip_outq (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire cstrip_pkg::push_t      push,
  output logic                        room,
  output logic                        q_valid,
  output cstrip_pkg::out_beat_t       q_head,
  input  wire                         q_pop
);

  cstrip_pkg::out_beat_t              entries_r [cstrip_pkg::QUEUE_DEPTH];
  logic [cstrip_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [cstrip_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [cstrip_pkg::QPTR_W-1:0]      wr_ptr_1;
  logic [cstrip_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [cstrip_pkg::QPTR_W-1:0]      rd_ptr_nxt;
  logic [cstrip_pkg::QCNT_W-1:0]      cnt_r;
  logic [cstrip_pkg::QCNT_W-1:0]      cnt_nxt;
  logic                               pop;

  assign pop        = q_pop && q_valid;
  assign wr_ptr_1   = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + cstrip_pkg::QPTR_W'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + cstrip_pkg::QPTR_W'(pop);
  assign cnt_nxt    = cnt_r + cstrip_pkg::QCNT_W'(push.n) - cstrip_pkg::QCNT_W'(pop);

  // room for a worst-case input beat
  assign room    = (cnt_r <= cstrip_pkg::QCNT_W'(cstrip_pkg::QUEUE_DEPTH - 2));
  assign q_valid = (cnt_r != '0);
  assign q_head  = entries_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) entries_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) entries_r[wr_ptr_1] <= push.r1;
  end

endmodule

`default_nettype wire

// ----- sv/comment_stripper.sv -----
// comment_stripper: streaming source comment filter, top level
// depends on cstrip_pkg, cstrip_if, cstrip_core, cstrip_outq
//
// Usage:
//   in_ch carries one raw text byte per beat (in_byte, is_last); is_last marks
//   the final byte of a text. out_ch carries kept bytes (out_byte, has_byte,
//   end_of_text); an empty beat with has_byte low closes a text that ended
//   with nothing to give. A slash is held back one byte to spot a comment
//   opener, so a byte may come out one input beat late or with the next one.
//   Throughput: one input beat per cycle while in_ch.ready is high. Each input
//   beat is scanned in the cycle it is taken and its zero to two results land
//   in a four-entry queue whose head drives out_ch. One input beat that gives
//   two results takes two output beats. in_ch.ready drops when the queue
//   cannot take two more results, i.e. while three or more results wait, which
//   a stalled receiver or a run of two-result beats brings about.
//   Reset (rst_n, synchronous, active low) empties the queue, clears the text
//   state and sets comment_modes to line-slash comments. The APB port writes
//   comment_modes at address 0; the user must write it only while no text is
//   in flight, as the block itself does not enforce this.
`default_nettype none

module comment_stripper (
  input  wire                           clk,
  input  wire                           rst_n,
  cstrip_in_if.sink                     in_ch,
  cstrip_out_if.source                  out_ch,
  input  wire                           cfg_psel,
  input  wire                           cfg_penable,
  input  wire                           cfg_pwrite,
  input  wire [cstrip_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire [cstrip_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [cstrip_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  logic [cstrip_pkg::MODES_W-1:0] modes_r;
  cstrip_pkg::text_state_t        st_r;
  cstrip_pkg::text_state_t        st_nxt;
  cstrip_pkg::push_t              core_push;
  cstrip_pkg::push_t              q_push;
  cstrip_pkg::out_beat_t          q_head;
  logic                           room;
  logic                           q_valid;
  logic                           in_acc;
  logic                           reg_sel;
  logic                           cfg_wr;

  // configuration register
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[cstrip_pkg::CFG_AW-1:2] == cstrip_pkg::REG_MODES);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && reg_sel;
  assign cfg_prdata = reg_sel ? cstrip_pkg::CFG_DW'(modes_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modes_r <= cstrip_pkg::MODES_RESET;
    end else if (cfg_wr) begin
      modes_r <= cfg_pwdata[cstrip_pkg::MODES_W-1:0];
    end
  end

  // input handshake
  assign in_ch.ready = room;
  assign in_acc      = in_ch.valid && room;

  // scanner
  cstrip_core u_core (
    .st     (st_r),
    .modes  (modes_r),
    .c      (in_ch.in_byte),
    .last   (in_ch.is_last),
    .st_nxt (st_nxt),
    .push   (core_push)
  );

  // text state advances on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // results enter the queue only for an accepted beat
  always_comb begin
    q_push = core_push;
    if (!in_acc) q_push.n = 2'd0;
  end

  cstrip_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .room    (room),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (out_ch.ready)
  );

  // output channel
  assign out_ch.valid       = q_valid;
  assign out_ch.out_byte    = q_head.out_byte;
  assign out_ch.has_byte    = q_head.has_byte;
  assign out_ch.end_of_text = q_head.end_of_text;

endmodule

`default_nettype wire

// ----- tb/comment_stripper_tb.sv -----
// comment_stripper_tb: self-checking testbench of the comment stripper
// drives raw text beats and apb mode writes, predicts kept bytes in a scoreboard class
// depends on cstrip_pkg, cstrip_if and comment_stripper
`timescale 1ns / 1ps

module comment_stripper_tb;
  import cstrip_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int SETTLE_CYCLES = 4;

  // mode register values built from the package bit positions
  localparam logic [MODES_W-1:0] M_SLASH = MODES_W'(1 << MODE_SLASH);
  localparam logic [MODES_W-1:0] M_HASH  = MODES_W'(1 << MODE_HASH);
  localparam logic [MODES_W-1:0] M_BLOCK = MODES_W'(1 << MODE_BLOCK);

  // an index past the only register, writes there must be ignored
  localparam logic [CFG_AW-3:0] REG_SPARE = 1'b1;

  // predicts kept bytes and checks them against the result channel
  class strip_tracker;
    logic [MODES_W-1:0] mode_bits;
    logic [7:0]         slash_byte;
    bit                 slash_held;
    logic [7:0]         last_raw;
    bit                 in_line;
    bit                 in_block;
    bit                 close_armed;
    out_beat_t          kept_q[$];
    int                 fault_count;

    function new();
      mode_bits   = MODES_RESET;
      fault_count = 0;
      clear_text();
    endfunction

    function void clear_text();
      slash_byte  = 8'h00;
      slash_held  = 1'b0;
      last_raw    = 8'h00;
      in_line     = 1'b0;
      in_block    = 1'b0;
      close_armed = 1'b0;
    endfunction

    function out_beat_t kept(logic [7:0] b);
      kept = '{out_byte: b, has_byte: 1'b1, end_of_text: 1'b0};
    endfunction

    // one raw beat accepted: advance the scanner, queue its kept bytes
    function void take_raw(logic [7:0] c, logic last);
      bit        blk;
      bit        slash_on;
      bit        hash_on;
      bit        unesc;
      bit        take;
      int        made;
      out_beat_t tail;
      blk      = mode_bits[MODE_BLOCK];
      slash_on = !blk && mode_bits[MODE_SLASH];
      hash_on  = !blk && mode_bits[MODE_HASH];
      unesc    = (last_raw != CH_BSLASH);
      made     = 0;

      if (in_line) begin
        if (c == CH_NL) in_line = 1'b0;
      end else if (in_block) begin
        if (close_armed && c == CH_SLASH) begin
          in_block    = 1'b0;
          close_armed = 1'b0;
        end else begin
          close_armed = (c == CH_STAR) && unesc;
        end
      end else begin
        take = 1'b1;
        // a held slash either opens a comment or goes out first
        if (slash_held) begin
          slash_held = 1'b0;
          if (blk && c == CH_STAR) begin
            in_block    = 1'b1;
            close_armed = 1'b0;
            take        = 1'b0;
          end else if (slash_on && c == CH_SLASH) begin
            in_line = 1'b1;
            take    = 1'b0;
          end else begin
            kept_q.push_back(kept(slash_byte));
            made++;
          end
        end
        if (take) begin
          if (hash_on && c == CH_HASH && unesc) begin
            in_line = 1'b1;
          end else if ((blk || slash_on) && c == CH_SLASH && unesc) begin
            slash_byte = c;
            slash_held = 1'b1;
          end else begin
            kept_q.push_back(kept(c));
            made++;
          end
        end
      end
      last_raw = c;

      // end of text: flush the held slash, mark the final beat
      if (last) begin
        if (slash_held) begin
          kept_q.push_back(kept(slash_byte));
          made++;
        end
        if (made == 0)
          kept_q.push_back('{out_byte: 8'h00, has_byte: 1'b0, end_of_text: 1'b0});
        tail = kept_q.pop_back();
        tail.end_of_text = 1'b1;
        kept_q.push_back(tail);
        clear_text();
      end
    endfunction

    // one result beat accepted: compare with the oldest expectation
    function void check_kept(out_beat_t got);
      out_beat_t want;
      if (kept_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected result byte=%02h has=%b eot=%b", $realtime,
                   got.out_byte, got.has_byte, got.end_of_text);
      end else begin
        want = kept_q.pop_front();
        if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
            got.end_of_text !== want.end_of_text) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: mismatch exp byte=%02h has=%b eot=%b got byte=%02h has=%b eot=%b",
                     $realtime, want.out_byte, want.has_byte, want.end_of_text,
                     got.out_byte, got.has_byte, got.end_of_text);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  cstrip_in_if  in_ch();
  cstrip_out_if out_ch();

  strip_tracker sb;
  bit           calm;
  int           idle_cycles;

  comment_stripper uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // biased toward the marker characters
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return CH_SLASH;
      2:       return CH_STAR;
      3:       return CH_HASH;
      4:       return CH_BSLASH;
      5:       return CH_NL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one raw beat, after a random gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // stop sending and let every expected beat drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.kept_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr[CFG_AW-1:2] == REG_MODES) sb.mode_bits = data[MODES_W-1:0];
  endtask

  // beat monitor: input beats are noted before result beats are checked
  always @(posedge clk) begin : monitor
    bit        took_in;
    bit        took_out;
    out_beat_t seen;
    if (rst_n) begin
      took_in  = in_ch.valid && in_ch.ready;
      took_out = out_ch.valid && out_ch.ready;
      if (took_in) sb.take_raw(in_ch.in_byte, in_ch.is_last);
      if (took_out) begin
        seen.out_byte    = out_ch.out_byte;
        seen.has_byte    = out_ch.has_byte;
        seen.end_of_text = out_ch.end_of_text;
        sb.check_kept(seen);
      end
      idle_cycles <= (took_in || took_out) ? 0 : idle_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= STALL_LIMIT);
    $display("comment_stripper verification failed");
    $finish;
  end

  initial begin
    int               sent;
    int               ph;
    int               burst;
    logic [MODES_W-1:0] mode;
    logic [7:0]       chunk[$];
    sb = new();
    calm = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.is_last <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mode, line slash: comment, escaped slash, byte extremes
    send_byte(8'h00, 1'b0);
    send_text("a//x\n\\/", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("/", 1'b1);
    // write past the register is ignored, so this is still a line comment
    settle();
    write_reg({REG_SPARE, 2'b00}, CFG_DW'(M_BLOCK));
    send_text("//", 1'b1);
    // block mode: opening star never closes, escaped star does not close
    settle();
    write_reg({REG_MODES, 2'b00}, CFG_DW'(M_BLOCK));
    send_text("/*/\\*/*/#", 1'b1);
    // both line kinds, escaped hash, then a held slash across a mode change
    settle();
    write_reg({REG_MODES, 2'b00}, CFG_DW'(M_SLASH | M_HASH));
    send_text("#\n\\#/", 1'b0);
    settle();
    write_reg({REG_MODES, 2'b00}, CFG_DW'(M_BLOCK));
    send_text("*q", 1'b1);

    // random phases, each with its own mode, texts may span phases
    sent = 0;
    ph = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      mode = (ph < 8) ? MODES_W'(ph) : MODES_W'($urandom_range(0, 7));
      write_reg({REG_MODES, 2'b00}, ($urandom() & ~CFG_DW'(7)) | CFG_DW'(mode));
      calm  = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(40, 120);
      while (burst > 0) begin
        chunk.delete();
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            chunk.push_back(CH_SLASH);
            chunk.push_back(CH_STAR);
            repeat ($urandom_range(0, 6)) chunk.push_back(pick_char());
            chunk.push_back(CH_STAR);
            chunk.push_back(CH_SLASH);
          end
          3, 4: begin
            chunk.push_back(CH_SLASH);
            chunk.push_back(CH_SLASH);
            repeat ($urandom_range(0, 6)) chunk.push_back(pick_char());
            chunk.push_back(CH_NL);
          end
          5: begin
            chunk.push_back(CH_HASH);
            repeat ($urandom_range(0, 6)) chunk.push_back(pick_char());
            chunk.push_back(CH_NL);
          end
          default: begin
            repeat ($urandom_range(1, 4)) chunk.push_back(pick_char());
          end
        endcase
        foreach (chunk[i]) send_byte(chunk[i], $urandom_range(0, 39) == 0);
        burst -= chunk.size();
        sent  += chunk.size();
      end
      ph++;
    end

    // drain and give stray beats a chance to show up
    settle();
    repeat (10) @(posedge clk);
    if (sb.fault_count == 0 && sb.kept_q.size() == 0)
      $display("comment_stripper verification clean");
    else
      $display("comment_stripper verification failed");
    $finish;
  end

endmodule
